@@ sv/dltq_pkg.sv @@
package dltq_pkg;

    // Default sizing of the timer list
    localparam int DEF_CAPACITY  = 16;
    localparam int DEF_TIME_BITS = 16;
    localparam int DEF_ID_BITS   = 16;

    // Request codes
    typedef enum logic [1:0] {
        OP_ADD  = 2'd0,
        OP_DEL  = 2'd1,
        OP_TICK = 2'd2,
        OP_NOP  = 2'd3
    } op_t;

    // Result status codes
    typedef enum logic [2:0] {
        ST_DONE      = 3'd0,
        ST_FULL      = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_EMPTY     = 3'd3,
        ST_RUNNING   = 3'd4,
        ST_EXPIRED   = 3'd5
    } status_t;

endpackage

@@ sv/delta_list_timer_queue_unit.sv @@
// Delta-list timer queue: up to CAPACITY timers kept sorted by expiry, each
// entry holding an id and its time relative to the entry before it.
//
// Request channel: a request (op, timer_value, seq_id) is taken at a rising
// edge where start is high and busy is low. op selects add, delete or tick;
// the unused code leaves the list alone and reports done.
// Result channel: done is high for exactly one cycle with status,
// head_valid, head_seq and head_remaining. There is no back-pressure: the
// receiver must take the result in that cycle.
//
// Busy stays high until a request is finished, and done is high in the first
// cycle in which busy is low again; a new request may already be accepted in
// that cycle. A tick works on the head entry alone, while add and delete walk
// the entry memory one entry per cycle, so their time grows with the fill
// count; an add to a full list skips the walk. Requests never overlap: a new
// one is taken only once the last has finished.
//
// Reset empties the list at once; the entry memory itself is not cleared,
// since only entries below the fill count are ever used.
module delta_list_timer_queue_unit
    import dltq_pkg::*;
#(
    parameter int CAPACITY  = DEF_CAPACITY,
    parameter int TIME_BITS = DEF_TIME_BITS,
    parameter int ID_BITS   = DEF_ID_BITS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [1:0]           op,
    input  logic [TIME_BITS-1:0] timer_value,
    input  logic [ID_BITS-1:0]   seq_id,
    output logic                 done,
    output logic [2:0]           status,
    output logic                 head_valid,
    output logic [ID_BITS-1:0]   head_seq,
    output logic [TIME_BITS-1:0] head_remaining
);

    // Entry index must reach CAPACITY itself; memory address need not
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int ADDR_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int MEM_DEPTH = 1 << ADDR_W;
    localparam int PC_W      = 4;

    typedef struct packed {
        logic [TIME_BITS-1:0] delta;
        logic [ID_BITS-1:0]   id;
    } entry_t;

    // Datapath actions driven by the control word
    typedef enum logic [3:0] {
        A_NONE,
        A_LATCH,
        A_ADD_STEP,
        A_ADD_LAST,
        A_SET_FULL,
        A_DEL_STEP,
        A_DEL_END,
        A_SET_NOTF,
        A_TICK,
        A_HEAD,
        A_OUT
    } act_t;

    // Sequencing of the step counter
    typedef enum logic [2:0] {
        BR_NEXT,
        BR_JUMP,
        BR_DISPATCH,
        BR_IF_FULL,
        BR_IF_EMPTY,
        BR_IF_MORE
    } br_t;

    typedef struct packed {
        act_t            act;
        br_t             br;
        logic [PC_W-1:0] target;
    } ctrl_t;

    // Program labels
    localparam logic [PC_W-1:0] L_IDLE     = PC_W'(0);
    localparam logic [PC_W-1:0] L_ADD      = PC_W'(1);
    localparam logic [PC_W-1:0] L_ADD_CHK  = PC_W'(2);
    localparam logic [PC_W-1:0] L_ADD_WALK = PC_W'(3);
    localparam logic [PC_W-1:0] L_ADD_END  = PC_W'(4);
    localparam logic [PC_W-1:0] L_FULL     = PC_W'(5);
    localparam logic [PC_W-1:0] L_DEL      = PC_W'(6);
    localparam logic [PC_W-1:0] L_DEL_WALK = PC_W'(7);
    localparam logic [PC_W-1:0] L_DEL_END  = PC_W'(8);
    localparam logic [PC_W-1:0] L_NOTF     = PC_W'(9);
    localparam logic [PC_W-1:0] L_TICK     = PC_W'(10);
    localparam logic [PC_W-1:0] L_HEAD     = PC_W'(11);
    localparam logic [PC_W-1:0] L_OUT      = PC_W'(12);

    // Microprogram: one control word per step
    function automatic ctrl_t ucode_rom(input logic [PC_W-1:0] a);
        ctrl_t w;
        case (a)
            L_IDLE:     w = '{A_LATCH,    BR_DISPATCH, L_IDLE};
            L_ADD:      w = '{A_NONE,     BR_IF_FULL,  L_FULL};
            L_ADD_CHK:  w = '{A_NONE,     BR_IF_EMPTY, L_ADD_END};
            L_ADD_WALK: w = '{A_ADD_STEP, BR_IF_MORE,  L_ADD_WALK};
            L_ADD_END:  w = '{A_ADD_LAST, BR_JUMP,     L_HEAD};
            L_FULL:     w = '{A_SET_FULL, BR_JUMP,     L_HEAD};
            L_DEL:      w = '{A_NONE,     BR_IF_EMPTY, L_NOTF};
            L_DEL_WALK: w = '{A_DEL_STEP, BR_IF_MORE,  L_DEL_WALK};
            L_DEL_END:  w = '{A_DEL_END,  BR_JUMP,     L_HEAD};
            L_NOTF:     w = '{A_SET_NOTF, BR_JUMP,     L_HEAD};
            L_TICK:     w = '{A_TICK,     BR_NEXT,     L_IDLE};
            L_HEAD:     w = '{A_HEAD,     BR_NEXT,     L_IDLE};
            L_OUT:      w = '{A_OUT,      BR_JUMP,     L_IDLE};
            default:    w = '{A_NONE,     BR_JUMP,     L_IDLE};
        endcase
        return w;
    endfunction

    // Entry memory: one write and one registered read per cycle
    entry_t mem [0:MEM_DEPTH-1];
    entry_t rd_reg;

    logic [PC_W-1:0]      pc_reg, pc_next;
    logic [CNT_W-1:0]     idx_reg, idx_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [TIME_BITS-1:0] acc_reg, acc_next;
    logic [ID_BITS-1:0]   key_reg, key_next;
    logic                 flag_reg, flag_next;
    status_t              status_reg, status_next;
    logic                 done_reg, done_next;
    logic                 hvalid_reg, hvalid_next;
    logic [ID_BITS-1:0]   hseq_reg, hseq_next;
    logic [TIME_BITS-1:0] hrem_reg, hrem_next;

    ctrl_t                ctrl;
    logic                 wr_en;
    logic [ADDR_W-1:0]    wr_addr;
    entry_t               wr_data;
    logic [CNT_W-1:0]     idx_m1;
    logic [CNT_W:0]       idx_p1;
    logic                 list_full, list_empty, more;
    logic [TIME_BITS:0]   fold_sum;
    logic [TIME_BITS-1:0] fold_sat;
    logic [TIME_BITS-1:0] tick_dec;
    logic [TIME_BITS-1:0] ins_sub;

    assign idx_m1     = idx_reg - CNT_W'(1);
    assign idx_p1     = {1'b0, idx_reg} + (CNT_W + 1)'(1);
    assign list_full  = (count_reg == CNT_W'(CAPACITY));
    assign list_empty = (count_reg == '0);
    assign more       = (idx_p1 < {1'b0, count_reg});

    // Fold the deleted delta into its successor, saturating
    assign fold_sum = {1'b0, rd_reg.delta} + {1'b0, acc_reg};
    assign fold_sat = fold_sum[TIME_BITS] ? '1 : fold_sum[TIME_BITS-1:0];
    assign tick_dec = (rd_reg.delta == '0) ? '0 : rd_reg.delta - TIME_BITS'(1);
    // Successor delta after an insert, or the displaced entry's own delta
    assign ins_sub  = rd_reg.delta - (flag_reg ? '0 : acc_reg);

    always_comb
    begin
        ctrl        = ucode_rom(pc_reg);
        pc_next     = pc_reg + PC_W'(1);
        idx_next    = idx_reg;
        count_next  = count_reg;
        acc_next    = acc_reg;
        key_next    = key_reg;
        flag_next   = flag_reg;
        status_next = status_reg;
        done_next   = 1'b0;
        hvalid_next = hvalid_reg;
        hseq_next   = hseq_reg;
        hrem_next   = hrem_reg;
        wr_en       = 1'b0;
        wr_addr     = idx_reg[ADDR_W-1:0];
        wr_data     = '{delta: acc_reg, id: key_reg};

        case (ctrl.br)
            BR_NEXT:     pc_next = pc_reg + PC_W'(1);
            BR_JUMP:     pc_next = ctrl.target;
            BR_DISPATCH:
            begin
                if (!start)
                    pc_next = pc_reg;
                else
                begin
                    case (op_t'(op))
                        OP_ADD:  pc_next = L_ADD;
                        OP_DEL:  pc_next = L_DEL;
                        OP_TICK: pc_next = L_TICK;
                        default: pc_next = L_HEAD;
                    endcase
                end
            end
            BR_IF_FULL:  if (list_full) pc_next = ctrl.target;
            BR_IF_EMPTY: if (list_empty) pc_next = ctrl.target;
            BR_IF_MORE:  if (more) pc_next = ctrl.target;
            default:     pc_next = L_IDLE;
        endcase

        case (ctrl.act)
            A_NONE: ;
            A_LATCH:
            begin
                // Point the read port at the head ahead of every request
                idx_next = '0;
                if (start)
                begin
                    acc_next    = timer_value;
                    key_next    = seq_id;
                    flag_next   = 1'b0;
                    status_next = ST_DONE;
                end
            end
            A_ADD_STEP:
            begin
                // Consume deltas until the slot is found, then ripple entries up
                if (!flag_reg && (acc_reg >= rd_reg.delta))
                    acc_next = acc_reg - rd_reg.delta;
                else
                begin
                    wr_en     = 1'b1;
                    acc_next  = ins_sub;
                    key_next  = rd_reg.id;
                    flag_next = 1'b1;
                end
                idx_next = idx_reg + CNT_W'(1);
            end
            A_ADD_LAST:
            begin
                wr_en      = 1'b1;
                count_next = count_reg + CNT_W'(1);
            end
            A_SET_FULL: status_next = ST_FULL;
            A_DEL_STEP:
            begin
                // Find the id, then move every later entry down by one
                if (!flag_reg)
                begin
                    if (rd_reg.id == key_reg)
                    begin
                        flag_next = 1'b1;
                        acc_next  = rd_reg.delta;
                    end
                end
                else
                begin
                    wr_en    = 1'b1;
                    wr_addr  = idx_m1[ADDR_W-1:0];
                    wr_data  = '{delta: fold_sat, id: rd_reg.id};
                    acc_next = '0;
                end
                idx_next = idx_reg + CNT_W'(1);
            end
            A_DEL_END:
            begin
                if (flag_reg)
                    count_next = count_reg - CNT_W'(1);
                else
                    status_next = ST_NOT_FOUND;
            end
            A_SET_NOTF: status_next = ST_NOT_FOUND;
            A_TICK:
            begin
                if (list_empty)
                    status_next = ST_EMPTY;
                else
                begin
                    wr_en       = 1'b1;
                    wr_data     = '{delta: tick_dec, id: rd_reg.id};
                    status_next = (tick_dec != '0) ? ST_RUNNING : ST_EXPIRED;
                end
            end
            A_HEAD: idx_next = '0;
            A_OUT:
            begin
                done_next   = 1'b1;
                hvalid_next = !list_empty;
                hseq_next   = list_empty ? '0 : rd_reg.id;
                hrem_next   = list_empty ? '0 : rd_reg.delta;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_reg <= mem[idx_next[ADDR_W-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg     <= L_IDLE;
            idx_reg    <= '0;
            count_reg  <= '0;
            flag_reg   <= 1'b0;
            status_reg <= ST_DONE;
            done_reg   <= 1'b0;
        end
        else
        begin
            pc_reg     <= pc_next;
            idx_reg    <= idx_next;
            count_reg  <= count_next;
            flag_reg   <= flag_next;
            status_reg <= status_next;
            done_reg   <= done_next;
        end
    end

    // Payload registers: no reset needed
    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        key_reg    <= key_next;
        hvalid_reg <= hvalid_next;
        hseq_reg   <= hseq_next;
        hrem_reg   <= hrem_next;
    end

    assign busy           = (pc_reg != L_IDLE);
    assign done           = done_reg;
    assign status         = status_reg;
    assign head_valid     = hvalid_reg;
    assign head_seq       = hseq_reg;
    assign head_remaining = hrem_reg;

endmodule

@@ sv/dltq_checker.sv @@
module dltq_checker
    import dltq_pkg::*;
#(
    parameter int TIME_BITS = DEF_TIME_BITS,
    parameter int ID_BITS   = DEF_ID_BITS
) (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 start,
    input logic                 busy,
    input logic                 done,
    input logic [2:0]           status,
    input logic                 head_valid,
    input logic [ID_BITS-1:0]   head_seq,
    input logic [TIME_BITS-1:0] head_remaining
);

    // A taken request keeps the unit busy until its result
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("request accepted but unit not busy");

    // A result only appears once the work is finished
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    // Empty list reports a cleared head
    a_empty_head: assert property (@(posedge clk) disable iff (!rst_n)
        done && !head_valid |-> (head_seq == '0) && (head_remaining == '0))
        else $error("empty list with non-zero head");

    // Tick status agrees with the head shown
    a_tick_head: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status == ST_RUNNING || status == ST_EXPIRED) |->
            head_valid && ((status == ST_RUNNING) == (head_remaining != '0)))
        else $error("tick status disagrees with head");

    a_tick_empty: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status == ST_EMPTY) |-> !head_valid)
        else $error("empty status with valid head");

endmodule

bind delta_list_timer_queue_unit dltq_checker #(
    .TIME_BITS (TIME_BITS),
    .ID_BITS   (ID_BITS)
) u_dltq_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .done           (done),
    .status         (status),
    .head_valid     (head_valid),
    .head_seq       (head_seq),
    .head_remaining (head_remaining)
);
